>>> design/dmwb_pkg.sv
`default_nettype none

package dmwb_pkg;

  localparam int LINE_COUNT = 512;
  localparam int IDX_W      = $clog2(LINE_COUNT);
  localparam int ADDR_W     = 29;
  localparam int DATA_W     = 32;
  localparam int LINE_AW    = ADDR_W - 4;
  localparam int TAG_W      = LINE_AW - IDX_W;
  localparam int WORD_AW    = IDX_W + 2;
  localparam int TENT_W     = TAG_W + 2;
  localparam int WORD_COUNT = LINE_COUNT * 4;

  typedef logic [1:0] op_t;
  localparam op_t OP_READ  = 2'd0;
  localparam op_t OP_WRITE = 2'd1;
  localparam op_t OP_FILL  = 2'd2;

  typedef enum logic [2:0] {
    KIND_READ  = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_WB    = 3'd2,
    KIND_REQ   = 3'd3,
    KIND_ERR   = 3'd4
  } kind_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic [DATA_W-1:0] bit_mask;
    logic [DATA_W-1:0] fill_data;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] mem_address;
    logic [DATA_W-1:0] data;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_ERR       = 3'd0,
    CMD_HIT       = 3'd1,
    CMD_MISS      = 3'd2,
    CMD_FILL      = 3'd3,
    CMD_FILL_LAST = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              is_write;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] mask;
    logic [1:0]        fword;
    logic [DATA_W-1:0] fdata;
    logic [TAG_W-1:0]  vic_tag;
    logic              vic_dirty;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
  } tag_entry_t;

  function automatic logic [IDX_W-1:0] line_of(input logic [ADDR_W-1:0] a);
    return a[IDX_W+3:4];
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_W-1:0] a);
    return a[ADDR_W-1:IDX_W+4];
  endfunction

  function automatic logic [WORD_AW-1:0] word_of(input logic [ADDR_W-1:0] a);
    return {a[IDX_W+3:4], a[3:2]};
  endfunction

endpackage

`default_nettype wire

>>> design/dmwb_ram.sv
`default_nettype none

module dmwb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> design/dmwb_front.sv
`default_nettype none

module dmwb_front
  import dmwb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire in_item_t         in_item,
  output logic                  tag_re,
  output logic      [IDX_W-1:0] tag_raddr,
  input  wire tag_entry_t       tag_rdata,
  input  wire logic             back_idle,
  input  wire logic             q_full,
  input  wire logic             q_empty,
  output logic                  q_push,
  output cmd_t                  q_data
);

  typedef enum logic [2:0] {
    F_IDLE  = 3'b001,
    F_CLASS = 3'b010,
    F_LOOK  = 3'b100
  } fstate_t;

  fstate_t           state_r, state_nxt;
  in_item_t          item_r, item_nxt;
  logic              await_r, await_nxt;
  logic [1:0]        fcnt_r, fcnt_nxt;
  logic              pend_wr_r, pend_wr_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [DATA_W-1:0] pend_data_r, pend_data_nxt;
  logic [DATA_W-1:0] pend_mask_r, pend_mask_nxt;

  assign in_full   = (state_r != F_IDLE);
  assign tag_raddr = line_of(item_r.address);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    await_nxt     = await_r;
    fcnt_nxt      = fcnt_r;
    pend_wr_nxt   = pend_wr_r;
    pend_addr_nxt = pend_addr_r;
    pend_data_nxt = pend_data_r;
    pend_mask_nxt = pend_mask_r;
    q_push        = 1'b0;
    q_data        = '0;
    q_data.kind   = CMD_ERR;
    tag_re        = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (in_push) begin
          item_nxt  = in_item;
          state_nxt = F_CLASS;
        end
      end
      F_CLASS: begin
        if (await_r) begin
          if (!q_full) begin
            q_push    = 1'b1;
            state_nxt = F_IDLE;
            if (item_r.op == OP_FILL) begin
              q_data.is_write = pend_wr_r;
              q_data.addr     = pend_addr_r;
              q_data.wdata    = pend_data_r;
              q_data.mask     = pend_mask_r;
              q_data.fword    = fcnt_r;
              q_data.fdata    = item_r.fill_data;
              if (fcnt_r == 2'd3) begin
                q_data.kind = CMD_FILL_LAST;
                await_nxt   = 1'b0;
                fcnt_nxt    = 2'd0;
              end else begin
                q_data.kind = CMD_FILL;
                fcnt_nxt    = fcnt_r + 2'd1;
              end
            end
          end
        end else if (item_r.op != OP_READ && item_r.op != OP_WRITE) begin
          if (!q_full) begin
            q_push    = 1'b1;
            state_nxt = F_IDLE;
          end
        end else if (back_idle && q_empty) begin
          // tag lookup only once all earlier line updates have landed
          tag_re    = 1'b1;
          state_nxt = F_LOOK;
        end
      end
      F_LOOK: begin
        q_push          = 1'b1;
        q_data.is_write = (item_r.op == OP_WRITE);
        q_data.addr     = item_r.address;
        q_data.wdata    = item_r.write_data;
        q_data.mask     = item_r.bit_mask;
        q_data.vic_tag  = tag_rdata.tag;
        q_data.vic_dirty = tag_rdata.valid & tag_rdata.dirty;
        if (tag_rdata.valid && tag_rdata.tag == tag_of(item_r.address)) begin
          q_data.kind = CMD_HIT;
        end else begin
          q_data.kind   = CMD_MISS;
          await_nxt     = 1'b1;
          fcnt_nxt      = 2'd0;
          pend_wr_nxt   = (item_r.op == OP_WRITE);
          pend_addr_nxt = item_r.address;
          pend_data_nxt = item_r.write_data;
          pend_mask_nxt = item_r.bit_mask;
        end
        state_nxt = F_IDLE;
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      await_r     <= 1'b0;
      fcnt_r      <= 2'd0;
      pend_wr_r   <= 1'b0;
      pend_addr_r <= '0;
      pend_data_r <= '0;
      pend_mask_r <= '0;
    end else begin
      state_r     <= state_nxt;
      await_r     <= await_nxt;
      fcnt_r      <= fcnt_nxt;
      pend_wr_r   <= pend_wr_nxt;
      pend_addr_r <= pend_addr_nxt;
      pend_data_r <= pend_data_nxt;
      pend_mask_r <= pend_mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

`default_nettype wire

>>> design/dmwb_cmdq.sv
`default_nettype none

module dmwb_cmdq
  import dmwb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  output logic      empty,
  input  wire logic pop,
  output cmd_t      head
);

  cmd_t       entries_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = entries_r[rptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> design/dmwb_back.sv
`default_nettype none

module dmwb_back
  import dmwb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  output logic                  q_pop,
  input  wire cmd_t             q_head,
  output logic                  idle,
  output logic                  tag_we,
  output logic      [IDX_W-1:0] tag_waddr,
  output tag_entry_t            tag_wdata,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output out_item_t             out_item
);

  typedef enum logic [7:0] {
    B_CLEAR = 8'b0000_0001,
    B_IDLE  = 8'b0000_0010,
    B_ERR   = 8'b0000_0100,
    B_ACCRD = 8'b0000_1000,
    B_ACC   = 8'b0001_0000,
    B_WBRD  = 8'b0010_0000,
    B_WBPUT = 8'b0100_0000,
    B_REQ   = 8'b1000_0000
  } bstate_t;

  bstate_t            state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic [1:0]         wb_r, wb_nxt;

  logic               d_we, d_re;
  logic [WORD_AW-1:0] d_waddr, d_raddr;
  logic [DATA_W-1:0]  d_wdata, d_rdata;

  out_item_t          ofifo_r [4];
  logic [1:0]         owp_r, orp_r;
  logic [2:0]         ocnt_r;
  logic               o_full, o_push, o_pop;
  out_item_t          o_data;

  dmwb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WORD_COUNT)
  ) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  assign idle = (state_r == B_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    clr_nxt   = clr_r;
    wb_nxt    = wb_r;
    q_pop     = 1'b0;
    tag_we    = 1'b0;
    tag_waddr = line_of(cmd_r.addr);
    tag_wdata = '0;
    d_we      = 1'b0;
    d_waddr   = word_of(cmd_r.addr);
    d_wdata   = (d_rdata & ~cmd_r.mask) | (cmd_r.wdata & cmd_r.mask);
    d_re      = 1'b0;
    d_raddr   = word_of(cmd_r.addr);
    o_push    = 1'b0;
    o_data    = '0;
    o_data.kind = KIND_ERR;
    case (state_r)
      B_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_r;
        clr_nxt   = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(LINE_COUNT - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          case (q_head.kind)
            CMD_ERR: begin
              state_nxt = B_ERR;
            end
            CMD_HIT: begin
              state_nxt = B_ACCRD;
            end
            CMD_MISS: begin
              wb_nxt    = 2'd0;
              state_nxt = q_head.vic_dirty ? B_WBRD : B_REQ;
            end
            CMD_FILL: begin
              d_we    = 1'b1;
              d_waddr = {line_of(q_head.addr), q_head.fword};
              d_wdata = q_head.fdata;
            end
            CMD_FILL_LAST: begin
              d_we      = 1'b1;
              d_waddr   = {line_of(q_head.addr), q_head.fword};
              d_wdata   = q_head.fdata;
              tag_we    = 1'b1;
              tag_waddr = line_of(q_head.addr);
              tag_wdata = '{valid: 1'b1, dirty: 1'b0, tag: tag_of(q_head.addr)};
              state_nxt = B_ACCRD;
            end
            default: begin
              state_nxt = B_ERR;
            end
          endcase
        end
      end
      B_ERR: begin
        if (!o_full) begin
          o_push      = 1'b1;
          o_data.kind = KIND_ERR;
          o_data.last = 1'b1;
          state_nxt   = B_IDLE;
        end
      end
      B_ACCRD: begin
        d_re      = 1'b1;
        state_nxt = B_ACC;
      end
      B_ACC: begin
        if (!o_full) begin
          o_push      = 1'b1;
          o_data.last = 1'b1;
          if (cmd_r.is_write) begin
            // merge under mask and mark the line dirty
            d_we        = 1'b1;
            tag_we      = 1'b1;
            tag_wdata   = '{valid: 1'b1, dirty: 1'b1, tag: tag_of(cmd_r.addr)};
            o_data.kind = KIND_WRITE;
          end else begin
            o_data.kind = KIND_READ;
            o_data.data = d_rdata;
          end
          state_nxt = B_IDLE;
        end
      end
      B_WBRD: begin
        d_re      = 1'b1;
        d_raddr   = {line_of(cmd_r.addr), wb_r};
        state_nxt = B_WBPUT;
      end
      B_WBPUT: begin
        if (!o_full) begin
          o_push             = 1'b1;
          o_data.kind        = KIND_WB;
          o_data.mem_address = {cmd_r.vic_tag, line_of(cmd_r.addr), wb_r, 2'b00};
          o_data.data        = d_rdata;
          wb_nxt             = wb_r + 2'd1;
          state_nxt          = (wb_r == 2'd3) ? B_REQ : B_WBRD;
        end
      end
      B_REQ: begin
        if (!o_full) begin
          o_push             = 1'b1;
          o_data.kind        = KIND_REQ;
          o_data.mem_address = {cmd_r.addr[ADDR_W-1:4], 4'b0000};
          o_data.last        = 1'b1;
          state_nxt          = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      clr_r   <= '0;
      wb_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      wb_r    <= wb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  // result queue
  assign o_full    = (ocnt_r == 3'd4);
  assign out_empty = (ocnt_r == 3'd0);
  assign out_item  = ofifo_r[orp_r];
  assign o_pop     = out_pop & ~out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 2'd0;
      orp_r  <= 2'd0;
      ocnt_r <= 3'd0;
    end else begin
      if (o_push) begin
        owp_r <= owp_r + 2'd1;
      end
      if (o_pop) begin
        orp_r <= orp_r + 2'd1;
      end
      case ({o_push, o_pop})
        2'b10:   ocnt_r <= ocnt_r + 3'd1;
        2'b01:   ocnt_r <= ocnt_r - 3'd1;
        default: ocnt_r <= ocnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) begin
      ofifo_r[owp_r] <= o_data;
    end
  end

endmodule

`default_nettype wire

>>> design/direct_mapped_writeback_dcache.sv
// a hit passes the tag lookup, the command queue and a data ram read; the tag lookup
// waits for the back end to drain, so a transaction is not looked up before the last ends
// a miss writes back a dirty victim first; fill words are taken one at a time
// reset: synchronous active-low; a clearing pass then walks the tag ram, all
// LINE_COUNT (512) lines, before the first command is carried out
`default_nettype none

module direct_mapped_writeback_dcache
  import dmwb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_push,
  output logic           in_full,
  input  wire in_item_t  in_item,
  output logic           out_empty,
  input  wire logic      out_pop,
  output out_item_t      out_item
);

  logic             tag_re, tag_we;
  logic [IDX_W-1:0] tag_raddr, tag_waddr;
  tag_entry_t       tag_rdata, tag_wdata;
  logic             back_idle;
  logic             q_full, q_empty, q_push, q_pop;
  cmd_t             q_data, q_head;

  dmwb_ram #(
    .WIDTH (TENT_W),
    .DEPTH (LINE_COUNT)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (tag_re),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  dmwb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .tag_re    (tag_re),
    .tag_raddr (tag_raddr),
    .tag_rdata (tag_rdata),
    .back_idle (back_idle),
    .q_full    (q_full),
    .q_empty   (q_empty),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  dmwb_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .empty     (q_empty),
    .pop       (q_pop),
    .head      (q_head)
  );

  dmwb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_head    (q_head),
    .idle      (back_idle),
    .tag_we    (tag_we),
    .tag_waddr (tag_waddr),
    .tag_wdata (tag_wdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
